### rtl/core/tds_pkg.sv
// ----------------------------------------------------------------------------
// tds_pkg
// Shared types and constants of the task dispatch scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tds_pkg;

  localparam int unsigned TASKS     = 16;
  localparam int unsigned IDX_W     = $clog2(TASKS);
  localparam int unsigned CNT_W     = $clog2(TASKS + 1);
  localparam int unsigned AGE_MUL   = 34953;
  localparam int unsigned AGE_SHIFT = 19;
  localparam int unsigned BONUS_W   = 13;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_RUN   = 2'd1,
    ST_SLEEP = 2'd2,
    ST_DONE  = 2'd3
  } status_e;

  localparam logic [1:0] OC_RAN = 2'd0;
  localparam logic [1:0] OC_IO  = 2'd1;
  localparam logic [1:0] OC_FIN = 2'd2;

  localparam logic [1:0] MODE_RR   = 2'd0;
  localparam logic [1:0] MODE_SJF  = 2'd1;
  localparam logic [1:0] MODE_SRTF = 2'd2;

  localparam logic CMD_ADMIT = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  typedef struct packed {
    logic [15:0] wait_cnt;
    logic [3:0]  sleep;
    logic [7:0]  quantum;
    logic [7:0]  burst;
  } entry_t;

  typedef struct packed {
    logic               vld;
    logic [IDX_W-1:0]   idx;
    logic               rr_cand;
    logic               any_cand;
    logic               sj_cand;
    logic               q_zero;
    logic [7:0]         burst;
    logic [BONUS_W-1:0] bonus;
  } pick_in_t;

  typedef struct packed {
    logic             busy;
    logic             rr_found;
    logic [IDX_W-1:0] rr_idx;
    logic             any_found;
    logic [IDX_W-1:0] any_idx;
    logic             sj_found;
    logic [IDX_W-1:0] sj_idx;
    logic             refill;
  } pick_out_t;

endpackage

`default_nettype wire

### rtl/core/tds_ram.sv
// ----------------------------------------------------------------------------
// tds_ram
// Per-task entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tds_ram (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [tds_pkg::IDX_W-1:0] waddr_i,
  input  tds_pkg::entry_t          wdata_i,
  input  wire [tds_pkg::IDX_W-1:0] raddr_i,
  output tds_pkg::entry_t          rdata_o
);
  import tds_pkg::*;

  entry_t mem [TASKS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/tds_pick.sv
// ----------------------------------------------------------------------------
// tds_pick
// Selection tracker: ages each swept entry's burst and keeps the round
// robin, any-task and shortest job candidates and the refill flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tds_pick (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      clear_i,
  input  wire [tds_pkg::IDX_W-1:0] rp_i,
  input  tds_pkg::pick_in_t        pick_i,
  output tds_pkg::pick_out_t       pick_o
);
  import tds_pkg::*;

  pick_in_t         st_q;
  logic             rr_hi_f_q, rr_lo_f_q, any_hi_f_q, any_lo_f_q, sj_f_q, refill_q;
  logic [IDX_W-1:0] rr_hi_q, rr_lo_q, any_hi_q, any_lo_q, sj_q;
  logic [7:0]       best_q;
  logic [7:0]       eff;
  logic             hi;
  logic [BONUS_W-1:0] burst_ext;
  logic [BONUS_W-1:0] diff;

  always_comb begin
    burst_ext = {{(BONUS_W-8){1'b0}}, st_q.burst};
    diff      = burst_ext - st_q.bonus;
    eff       = (burst_ext > st_q.bonus) ? diff[7:0] : 8'd0;
    hi        = st_q.idx >= rp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      rr_hi_f_q  <= 1'b0;
      rr_lo_f_q  <= 1'b0;
      any_hi_f_q <= 1'b0;
      any_lo_f_q <= 1'b0;
      sj_f_q     <= 1'b0;
      refill_q   <= 1'b0;
      rr_hi_q    <= '0;
      rr_lo_q    <= '0;
      any_hi_q   <= '0;
      any_lo_q   <= '0;
      sj_q       <= '0;
      best_q     <= '0;
    end else if (clear_i) begin
      st_q       <= '0;
      rr_hi_f_q  <= 1'b0;
      rr_lo_f_q  <= 1'b0;
      any_hi_f_q <= 1'b0;
      any_lo_f_q <= 1'b0;
      sj_f_q     <= 1'b0;
      refill_q   <= 1'b0;
    end else begin
      st_q <= pick_i;
      if (st_q.vld) begin
        if (st_q.rr_cand && hi && !rr_hi_f_q) begin
          rr_hi_f_q <= 1'b1;
          rr_hi_q   <= st_q.idx;
        end
        if (st_q.rr_cand && !hi && !rr_lo_f_q) begin
          rr_lo_f_q <= 1'b1;
          rr_lo_q   <= st_q.idx;
        end
        if (st_q.any_cand && hi && !any_hi_f_q) begin
          any_hi_f_q <= 1'b1;
          any_hi_q   <= st_q.idx;
        end
        if (st_q.any_cand && !hi && !any_lo_f_q) begin
          any_lo_f_q <= 1'b1;
          any_lo_q   <= st_q.idx;
        end
        if (st_q.sj_cand && (!sj_f_q || eff < best_q)) begin
          sj_f_q <= 1'b1;
          sj_q   <= st_q.idx;
          best_q <= eff;
        end
        if (st_q.q_zero) begin
          refill_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    pick_o.busy      = st_q.vld;
    pick_o.rr_found  = rr_hi_f_q | rr_lo_f_q;
    pick_o.rr_idx    = rr_hi_f_q ? rr_hi_q : rr_lo_q;
    pick_o.any_found = any_hi_f_q | any_lo_f_q;
    pick_o.any_idx   = any_hi_f_q ? any_hi_q : any_lo_q;
    pick_o.sj_found  = sj_f_q;
    pick_o.sj_idx    = sj_q;
    pick_o.refill    = refill_q;
  end

endmodule

`default_nettype wire

### rtl/core/task_dispatch_scheduler_with_aging.sv
// ----------------------------------------------------------------------------
// task_dispatch_scheduler_with_aging
// Per-tick dispatcher over sixteen task slots with round robin, shortest
// job and shortest remaining time policies and wait-based aging.
// ----------------------------------------------------------------------------
// The block handles one item at a time. An admit item passes through the
// admit and emit states before its result is offered. A tick item sweeps
// the per-task entry memory once to wake sleepers and rank candidates,
// and, when a task is dispatched or the round robin quanta are refilled,
// once more to age waiting tasks and charge the chosen one, one entry a
// cycle through the single read port; an idle tick skips the second sweep,
// and when the task dispatched last is still running, the outcome of that
// dispatch is read and written back before the first sweep. The next item
// can be accepted as soon as the result is offered; a result that is still
// waiting holds the block before it offers the next one. Task status lies
// in flip-flops and comes out of reset with every slot marked done.
`default_nettype none

module task_dispatch_scheduler_with_aging (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  // task_slot[3:0], initial_burst[11:4], last_outcome[13:12],
  // sleep_ticks[17:14], refill_burst[25:18]
  input  wire [31:0] s_axis_tdata,
  // cmd
  input  wire        s_axis_tuser,
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  // run_slot[3:0], all_finished[4]
  output logic [7:0] m_axis_tdata,
  // dispatched
  output logic       m_axis_tuser,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [2:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  import tds_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ADMIT, S_OC_RD, S_OC_WR, S_WAKE, S_DISP, S_EMIT
  } state_e;

  state_e           state_q;
  logic [1:0]       policy_q;
  logic [7:0]       quantum_q;
  logic [3:0]       slot_q;
  logic [7:0]       init_q;
  logic [1:0]       oc_q;
  logic [3:0]       sleep_q;
  logic [7:0]       refill_b_q;
  status_e          status_q [TASKS];
  logic [IDX_W-1:0] rp_q, last_q, rd_idx_q, sel_q;
  logic             lv_q, rd_v_q, sel_v_q, refill_q;
  logic [CNT_W-1:0] cnt_q;
  logic             m_valid_q, m_disp_q, m_fin_q;
  logic [3:0]       m_slot_q;

  logic             rr, every_done, sweep_done, wake_end, keep;
  logic [7:0]       qv;
  logic [IDX_W+3:0] slot_ext, sel_ext;
  logic             slot_ok;
  logic [IDX_W-1:0] slot_idx, cnt_idx;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, rdata, wake_e, disp_e;
  status_e          ws, new_st, ds;
  logic [31:0]      prod;
  pick_in_t         pk_in;
  pick_out_t        pk_out;
  logic             nsel_v, nrefill;
  logic [IDX_W-1:0] nsel;
  logic [TASKS-1:0] run_vec;

  assign rr       = !(policy_q == MODE_SJF || policy_q == MODE_SRTF);
  assign qv       = (quantum_q == 8'd0) ? 8'd1 : quantum_q;
  assign slot_ext = {{IDX_W{1'b0}}, slot_q};
  assign slot_ok  = slot_ext < (IDX_W+4)'(TASKS);
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign cnt_idx  = cnt_q[IDX_W-1:0];
  assign sel_ext  = {4'b0, sel_q};
  assign sweep_done = (cnt_q == CNT_W'(TASKS)) && !rd_v_q;
  assign wake_end = sweep_done && !pk_out.busy;
  assign keep     = (policy_q == MODE_SJF) && lv_q && (status_q[last_q] == ST_RUN);

  always_comb begin
    every_done = 1'b1;
    for (int i = 0; i < TASKS; i++) begin
      run_vec[i] = status_q[i] == ST_RUN;
      if (status_q[i] != ST_DONE) begin
        every_done = 1'b0;
      end
    end
  end

  always_comb begin
    ws     = status_q[rd_idx_q];
    wake_e = rdata;
    new_st = ws;
    if (ws == ST_SLEEP) begin
      wake_e.sleep = (rdata.sleep != 4'd0) ? rdata.sleep - 4'd1 : 4'd0;
      if (wake_e.sleep == 4'd0) begin
        new_st = ST_READY;
        if (rr) begin
          wake_e.quantum = qv;
        end else begin
          wake_e.burst = refill_b_q;
        end
      end
    end
    prod           = {16'd0, wake_e.wait_cnt} * 32'(AGE_MUL);
    pk_in.vld      = (state_q == S_WAKE) && rd_v_q;
    pk_in.idx      = rd_idx_q;
    pk_in.any_cand = (new_st == ST_READY) || (new_st == ST_RUN);
    pk_in.rr_cand  = pk_in.any_cand && (wake_e.quantum != 8'd0);
    pk_in.sj_cand  = (new_st == ST_READY) ||
                     ((policy_q == MODE_SRTF) && (new_st == ST_RUN));
    pk_in.q_zero   = (new_st != ST_DONE) && (wake_e.quantum == 8'd0);
    pk_in.burst    = wake_e.burst;
    pk_in.bonus    = prod[AGE_SHIFT+BONUS_W-1:AGE_SHIFT];
  end

  always_comb begin
    ds     = status_q[rd_idx_q];
    disp_e = rdata;
    if (refill_q && ds != ST_DONE) begin
      disp_e.quantum = qv;
    end
    if (sel_v_q && rd_idx_q == sel_q) begin
      if (rr) begin
        disp_e.quantum = (disp_e.quantum != 8'd0) ? disp_e.quantum - 8'd1 : 8'd0;
      end else begin
        disp_e.burst = (disp_e.burst != 8'd0) ? disp_e.burst - 8'd1 : 8'd0;
      end
    end else if (ds == ST_READY && disp_e.wait_cnt != 16'hFFFF) begin
      disp_e.wait_cnt = disp_e.wait_cnt + 16'd1;
    end
  end

  always_comb begin
    nsel_v  = 1'b0;
    nsel    = pk_out.sj_idx;
    nrefill = 1'b0;
    if (rr) begin
      if (pk_out.rr_found) begin
        nsel_v = 1'b1;
        nsel   = pk_out.rr_idx;
      end else if (pk_out.refill) begin
        nrefill = 1'b1;
        nsel_v  = pk_out.any_found;
        nsel    = pk_out.any_idx;
      end
    end else if (keep) begin
      nsel_v = 1'b1;
      nsel   = last_q;
    end else begin
      nsel_v = pk_out.sj_found;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx_q;
    mem_wdata = rdata;
    mem_raddr = cnt_idx;
    unique case (state_q)
      S_ADMIT: begin
        mem_we    = slot_ok;
        mem_waddr = slot_idx;
        mem_wdata = '{wait_cnt: 16'd0, sleep: 4'd0, quantum: qv, burst: init_q};
      end
      S_OC_RD: begin
        mem_raddr = last_q;
      end
      S_OC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = last_q;
        if (oc_q == OC_IO) begin
          mem_wdata.sleep = sleep_q;
        end
      end
      S_WAKE: begin
        mem_we    = rd_v_q;
        mem_wdata = wake_e;
      end
      S_DISP: begin
        mem_we    = rd_v_q;
        mem_wdata = disp_e;
      end
      default: begin
      end
    endcase
  end

  tds_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  tds_pick u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (state_q != S_WAKE),
    .rp_i    (rp_q),
    .pick_i  (pk_in),
    .pick_o  (pk_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= MODE_RR;
      quantum_q <= 8'd3;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_QUANTUM) begin
        quantum_q <= pwdata[7:0];
      end else begin
        policy_q <= pwdata[1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_POLICY) ? {30'd0, policy_q} : {24'd0, quantum_q};
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      for (int i = 0; i < TASKS; i++) begin
        status_q[i] <= ST_DONE;
      end
      rp_q       <= '0;
      last_q     <= '0;
      lv_q       <= 1'b0;
      rd_v_q     <= 1'b0;
      rd_idx_q   <= '0;
      cnt_q      <= '0;
      sel_v_q    <= 1'b0;
      sel_q      <= '0;
      refill_q   <= 1'b0;
      m_valid_q  <= 1'b0;
      m_disp_q   <= 1'b0;
      m_slot_q   <= '0;
      m_fin_q    <= 1'b0;
      slot_q     <= '0;
      init_q     <= '0;
      oc_q       <= '0;
      sleep_q    <= '0;
      refill_b_q <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && state_q != S_EMIT) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            slot_q     <= s_axis_tdata[3:0];
            init_q     <= s_axis_tdata[11:4];
            oc_q       <= s_axis_tdata[13:12];
            sleep_q    <= s_axis_tdata[17:14];
            refill_b_q <= s_axis_tdata[25:18];
            cnt_q      <= '0;
            rd_v_q     <= 1'b0;
            if (s_axis_tuser == CMD_ADMIT) begin
              state_q <= S_ADMIT;
            end else if (lv_q && status_q[last_q] == ST_RUN) begin
              state_q <= S_OC_RD;
            end else begin
              state_q <= S_WAKE;
            end
          end
        end
        S_ADMIT: begin
          if (slot_ok) begin
            status_q[slot_idx] <= ST_READY;
            if (lv_q && last_q == slot_idx) begin
              lv_q <= 1'b0;
            end
          end
          sel_v_q <= 1'b0;
          state_q <= S_EMIT;
        end
        S_OC_RD: begin
          state_q <= S_OC_WR;
        end
        S_OC_WR: begin
          if (oc_q == OC_FIN) begin
            status_q[last_q] <= ST_DONE;
            lv_q             <= 1'b0;
          end else if (oc_q == OC_IO) begin
            status_q[last_q] <= ST_SLEEP;
            lv_q             <= 1'b0;
          end else if (rr && rdata.quantum == 8'd0) begin
            status_q[last_q] <= ST_READY;
            rp_q <= (last_q == IDX_W'(TASKS - 1)) ? '0 : last_q + 1'b1;
          end
          state_q <= S_WAKE;
        end
        S_WAKE: begin
          if (cnt_q != CNT_W'(TASKS)) begin
            cnt_q    <= cnt_q + 1'b1;
            rd_v_q   <= 1'b1;
            rd_idx_q <= cnt_idx;
          end else begin
            rd_v_q <= 1'b0;
          end
          if (rd_v_q && ws == ST_SLEEP) begin
            status_q[rd_idx_q] <= new_st;
          end
          if (wake_end) begin
            sel_v_q  <= nsel_v;
            sel_q    <= nsel;
            refill_q <= nrefill;
            cnt_q    <= '0;
            if (nsel_v) begin
              for (int i = 0; i < TASKS; i++) begin
                if (IDX_W'(i) == nsel) begin
                  status_q[i] <= ST_RUN;
                end else if (status_q[i] == ST_RUN) begin
                  status_q[i] <= ST_READY;
                end
              end
              if (rr) begin
                rp_q <= nsel;
              end
              last_q <= nsel;
              lv_q   <= 1'b1;
            end else begin
              lv_q <= 1'b0;
            end
            state_q <= (nsel_v || nrefill) ? S_DISP : S_EMIT;
          end
        end
        S_DISP: begin
          if (cnt_q != CNT_W'(TASKS)) begin
            cnt_q    <= cnt_q + 1'b1;
            rd_v_q   <= 1'b1;
            rd_idx_q <= cnt_idx;
          end else begin
            rd_v_q <= 1'b0;
          end
          if (sweep_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_disp_q  <= sel_v_q;
            m_slot_q  <= sel_v_q ? sel_ext[3:0] : 4'd0;
            m_fin_q   <= every_done;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'd0, m_fin_q, m_slot_q};
  assign m_axis_tuser  = m_disp_q;

`ifndef SYNTHESIS
  a_one_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(run_vec) <= 1)
    else $error("more than one task is running");

  a_disp_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && m_valid_q && m_disp_q) |-> (lv_q && status_q[last_q] == ST_RUN))
    else $error("dispatched result does not match the running task");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_EMIT) |-> !mem_we)
    else $error("entry memory written outside an item");
`endif

endmodule

`default_nettype wire
